>>> src/prft_pkg.sv
`timescale 1ns / 1ps
package prft_pkg;
   localparam int MaxRules = 64;
   localparam int IdxW = $clog2(MaxRules);
   localparam int NumW = $clog2(MaxRules + 1);
   localparam logic [7:0] ProtoTcp = 8'd6;
   localparam logic [7:0] ProtoUdp = 8'd17;
   localparam logic DirIn = 1'b0;
   localparam logic DirOut = 1'b1;

   typedef enum logic [1:0] {
      CMD_MATCH = 2'd0,
      CMD_SET = 2'd1,
      CMD_READ = 2'd2,
      CMD_REWIND = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_ADDED = 2'd0,
      ST_REMOVED = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   // One classified item, passed from the front end to the back end.
   typedef struct packed {
      cmd_type cmd;
      logic [31:0] addr;
      logic [15:0] port;
      logic [7:0] proto;
      logic dir;
      logic en;
      logic [31:0] init;
      logic hit;
      logic [IdxW-1:0] hit_idx;
   } work_type;

   typedef struct packed {
      logic drop;
      status_type status;
      logic [5:0] index;
      logic [31:0] addr;
      logic [15:0] port;
      logic [7:0] proto;
      logic dir;
      logic en;
      logic [31:0] count;
      logic [6:0] total;
   } result_type;
endpackage

>>> src/prft_front.sv
`timescale 1ns / 1ps
module prft_front import prft_pkg::*; (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_stall,
   input work_type in_work,
   input logic [MaxRules-1:0][31:0] key_addr,
   input logic [MaxRules-1:0][15:0] key_port,
   input logic [MaxRules-1:0][7:0] key_proto,
   input logic [MaxRules-1:0] key_dir,
   input logic [NumW-1:0] rule_num,
   input logic busy,
   output logic q_valid,
   output work_type q_work,
   input logic q_take
);
   logic [MaxRules-1:0] match_vec;
   logic valid_ff;
   work_type work_ff, work_in;
   logic [IdxW-1:0] first_idx;
   logic any_hit;
   logic set_cmd, ok_proto;

   // One-entry queue: the slot is freed by the back end; a new item is only
   // admitted while the back end holds no item, since the compare uses the table.
   assign in_stall = valid_ff || busy;

   assign set_cmd = (in_work.cmd == CMD_SET);
   assign ok_proto = (in_work.proto == ProtoTcp) || (in_work.proto == ProtoUdp);

   always_comb begin
      for (int i = 0; i < MaxRules; i++) begin
         logic a_eq, p_eq, ctl_eq, live;
         a_eq = (key_addr[i] == in_work.addr);
         p_eq = (key_port[i] == in_work.port);
         ctl_eq = (key_proto[i] == in_work.proto) && (key_dir[i] == in_work.dir);
         live = (NumW'(i) < rule_num);
         if (set_cmd)
            match_vec[i] = live && a_eq && p_eq && ctl_eq;
         else
            match_vec[i] = live && ctl_eq && ok_proto &&
               ((key_addr[i] == 32'd0 && p_eq) || (a_eq && key_port[i] == 16'd0) ||
                (a_eq && p_eq));
      end
   end

   always_comb begin
      first_idx = '0;
      any_hit = 1'b0;
      for (int i = MaxRules - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            first_idx = IdxW'(i);
            any_hit = 1'b1;
         end
      end
      work_in = in_work;
      work_in.hit = any_hit;
      work_in.hit_idx = first_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && !in_stall) begin
         valid_ff <= 1'b1;
      end else if (q_take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         work_ff <= work_in;
      end
   end

   assign q_valid = valid_ff;
   assign q_work = work_ff;

   a_take: assert property (@(posedge clock) disable iff (reset) q_take |-> valid_ff)
      else $error("take without item");
   a_noacc: assert property (@(posedge clock) disable iff (reset) valid_ff |-> in_stall)
      else $error("accept while full");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !q_take) |=> valid_ff)
      else $error("item lost");
endmodule

>>> src/prft_back.sv
`timescale 1ns / 1ps
module prft_back import prft_pkg::*; (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input work_type q_work,
   output logic q_take,
   output logic [MaxRules-1:0][31:0] key_addr,
   output logic [MaxRules-1:0][15:0] key_port,
   output logic [MaxRules-1:0][7:0] key_proto,
   output logic [MaxRules-1:0] key_dir,
   output logic [NumW-1:0] rule_num,
   output logic busy,
   output logic out_valid,
   output result_type out_res,
   input logic out_stall
);
   logic [MaxRules-1:0][31:0] addr_ff;
   logic [MaxRules-1:0][15:0] port_ff;
   logic [MaxRules-1:0][7:0] proto_ff;
   logic [MaxRules-1:0] dir_ff, en_ff;
   logic [MaxRules-1:0][31:0] cnt_ff;
   logic [NumW-1:0] num_ff, num_in;
   logic [NumW-1:0] cur_ff, cur_in;
   logic [IdxW-1:0] rd_idx;
   logic valid_ff;
   result_type res_ff, res_in;
   logic do_add, do_rem, do_cnt;

   assign q_take = q_valid && (!valid_ff || !out_stall);
   assign busy = valid_ff;
   assign rd_idx = (cur_ff >= NumW'(MaxRules)) ? '0 : cur_ff[IdxW-1:0];

   always_comb begin
      res_in = '0;
      num_in = num_ff;
      cur_in = cur_ff;
      do_add = 1'b0;
      do_rem = 1'b0;
      do_cnt = 1'b0;
      unique case (q_work.cmd)
         CMD_MATCH: begin
            if (q_work.hit) begin
               do_cnt = 1'b1;
               res_in.drop = 1'b1;
               res_in.index = 6'(q_work.hit_idx);
            end
         end
         CMD_SET: begin
            if (q_work.hit) begin
               if (q_work.en) begin
                  res_in.status = ST_DUPLICATE;
               end else begin
                  do_rem = 1'b1;
                  num_in = num_ff - 1'b1;
                  res_in.status = ST_REMOVED;
               end
            end else if (q_work.en && num_ff < NumW'(MaxRules)) begin
               do_add = 1'b1;
               num_in = num_ff + 1'b1;
               res_in.status = ST_ADDED;
            end else begin
               res_in.status = ST_IGNORED;
            end
         end
         CMD_READ: begin
            res_in.index = 6'(rd_idx);
            res_in.addr = addr_ff[rd_idx];
            res_in.port = port_ff[rd_idx];
            res_in.proto = proto_ff[rd_idx];
            res_in.dir = dir_ff[rd_idx];
            res_in.en = en_ff[rd_idx];
            res_in.count = cnt_ff[rd_idx];
            cur_in = NumW'(rd_idx) + 1'b1;
         end
         CMD_REWIND: cur_in = '0;
         default: ;
      endcase
      res_in.total = 7'(num_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         port_ff <= '0;
         proto_ff <= '0;
         dir_ff <= '0;
         en_ff <= '0;
         cnt_ff <= '0;
         num_ff <= '0;
         cur_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (q_take) valid_ff <= 1'b1;
         else if (valid_ff && !out_stall) valid_ff <= 1'b0;
         if (q_take) begin
            num_ff <= num_in;
            cur_ff <= cur_in;
            if (do_cnt) cnt_ff[q_work.hit_idx] <= cnt_ff[q_work.hit_idx] + 32'd1;
            if (do_add) begin
               addr_ff[num_ff[IdxW-1:0]] <= q_work.addr;
               port_ff[num_ff[IdxW-1:0]] <= q_work.port;
               proto_ff[num_ff[IdxW-1:0]] <= q_work.proto;
               dir_ff[num_ff[IdxW-1:0]] <= q_work.dir;
               en_ff[num_ff[IdxW-1:0]] <= 1'b1;
               cnt_ff[num_ff[IdxW-1:0]] <= q_work.init;
            end
            if (do_rem) begin
               for (int m = 0; m < MaxRules - 1; m++) begin
                  if (IdxW'(m) >= q_work.hit_idx && NumW'(m + 1) < num_ff) begin
                     addr_ff[m] <= addr_ff[m+1];
                     port_ff[m] <= port_ff[m+1];
                     proto_ff[m] <= proto_ff[m+1];
                     dir_ff[m] <= dir_ff[m+1];
                     en_ff[m] <= en_ff[m+1];
                     cnt_ff[m] <= cnt_ff[m+1];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_take) res_ff <= res_in;
   end

   assign key_addr = addr_ff;
   assign key_port = port_ff;
   assign key_proto = proto_ff;
   assign key_dir = dir_ff;
   assign rule_num = num_ff;
   assign out_valid = valid_ff;
   assign out_res = res_ff;

   a_num: assert property (@(posedge clock) disable iff (reset) num_ff <= NumW'(MaxRules))
      else $error("rule count overflow");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_stall) |=> (valid_ff && $stable(res_ff)))
      else $error("result changed under stall");
   a_total: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (res_ff.total == 7'(num_ff)))
      else $error("total mismatch");
endmodule

>>> src/packet_rule_filter_table.sv
`timescale 1ns / 1ps
// A request beat is registered in the queue slot and then in the response register.
// A request beat is held off while the queue slot or the response register is occupied,
// so the next one is taken in the cycle after the response beat leaves.
// Reset (synchronous, active high) clears every rule slot, the rule count and the
// read cursor at once, and empties the queue and the response register.
module packet_rule_filter_table import prft_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_command,
   input logic [31:0] req_ip_addr,
   input logic [15:0] req_port,
   input logic [7:0] req_proto,
   input logic req_direction,
   input logic req_enable,
   input logic [31:0] req_initial_count,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic rsp_drop,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_entry_index,
   output logic [31:0] rsp_entry_addr,
   output logic [15:0] rsp_entry_port,
   output logic [7:0] rsp_entry_proto,
   output logic rsp_entry_direction,
   output logic rsp_entry_enable,
   output logic [31:0] rsp_entry_count,
   output logic [6:0] rsp_rule_total
);
   work_type in_work, q_work;
   result_type res;
   logic [MaxRules-1:0][31:0] key_addr;
   logic [MaxRules-1:0][15:0] key_port;
   logic [MaxRules-1:0][7:0] key_proto;
   logic [MaxRules-1:0] key_dir;
   logic [NumW-1:0] rule_num;
   logic busy, q_valid, q_take;

   // The front end fills in the hit flag and the first matching index.
   always_comb begin
      in_work = '0;
      in_work.cmd = cmd_type'(req_command);
      in_work.addr = req_ip_addr;
      in_work.port = req_port;
      in_work.proto = req_proto;
      in_work.dir = req_direction;
      in_work.en = req_enable;
      in_work.init = req_initial_count;
   end

   // The front end classifies each beat against the live table.
   prft_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall), .in_work(in_work),
      .key_addr(key_addr), .key_port(key_port), .key_proto(key_proto),
      .key_dir(key_dir), .rule_num(rule_num), .busy(busy),
      .q_valid(q_valid), .q_work(q_work), .q_take(q_take)
   );

   // The back end updates the table and holds the response beat.
   prft_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_work(q_work), .q_take(q_take),
      .key_addr(key_addr), .key_port(key_port), .key_proto(key_proto),
      .key_dir(key_dir), .rule_num(rule_num), .busy(busy),
      .out_valid(rsp_valid), .out_res(res), .out_stall(rsp_stall)
   );

   assign rsp_drop = res.drop;
   assign rsp_status = res.status;
   assign rsp_entry_index = res.index;
   assign rsp_entry_addr = res.addr;
   assign rsp_entry_port = res.port;
   assign rsp_entry_proto = res.proto;
   assign rsp_entry_direction = res.dir;
   assign rsp_entry_enable = res.en;
   assign rsp_entry_count = res.count;
   assign rsp_rule_total = res.total;
endmodule
